@@ src/nal_unit_rbsp_extract_macros.svh @@
// Assertion macros for the checks in nal_unit_rbsp_extract.sv.
`ifndef NAL_UNIT_RBSP_EXTRACT_MACROS_SVH
`define NAL_UNIT_RBSP_EXTRACT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NURE_CHECK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nure check failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define NURE_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nure check failed (next cycle)");

`endif

@@ src/nure_pkg.sv @@
`timescale 1ns / 1ps

package nure_pkg;

  localparam logic [7:0] NalTypeMask   = 8'h1f;
  localparam logic [7:0] ExtFlagBit    = 8'h80;
  localparam logic [7:0] EpbByte       = 8'h03;
  localparam logic [31:0] MinUnitLen   = 32'd4;

  localparam logic [7:0] TypePrefix     = 8'd14;
  localparam logic [7:0] TypeSliceExt   = 8'd20;
  localparam logic [7:0] TypeSliceExt3d = 8'd21;

  localparam logic [2:0] ExtHeaderSkip  = 3'd3;
  localparam logic [2:0] Skip3dFlagSet  = 3'd1;
  localparam logic [2:0] Skip3dFlagClr  = 3'd2;
  localparam logic [1:0] ZeroRunMax     = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        unit_start;
    logic [31:0] unit_length;
  } in_beat_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       unit_end;
    logic       unit_error;
  } res_t;

endpackage

@@ src/nure_core.sv @@
`timescale 1ns / 1ps

// Per-byte parsing state and the decision for one byte of a unit.
module nure_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  nure_pkg::in_beat_t beat,
  output nure_pkg::res_t     res
);

  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [2:0]  header_skip_left, header_skip_left_next;
  logic        await_extension_flag, await_extension_flag_next;
  logic [1:0]  zero_run, zero_run_next;
  logic        unit_rejected, unit_rejected_next;

  logic [7:0]  nal_type;
  logic        last;

  assign nal_type = beat.data_byte & nure_pkg::NalTypeMask;
  assign last     = (bytes_remaining == 32'd1);

  always_comb begin
    bytes_remaining_next      = bytes_remaining;
    header_skip_left_next     = header_skip_left;
    await_extension_flag_next = await_extension_flag;
    zero_run_next             = zero_run;
    unit_rejected_next        = unit_rejected;
    res                       = '0;

    if (beat.unit_start) begin
      zero_run_next             = '0;
      await_extension_flag_next = 1'b0;
      header_skip_left_next     = '0;
      if (beat.unit_length < nure_pkg::MinUnitLen) begin
        unit_rejected_next   = 1'b1;
        bytes_remaining_next = (beat.unit_length == 32'd0) ? 32'd0
                                                           : beat.unit_length - 32'd1;
        res.emit       = 1'b1;
        res.unit_end   = 1'b1;
        res.unit_error = 1'b1;
      end else begin
        unit_rejected_next   = 1'b0;
        bytes_remaining_next = beat.unit_length - 32'd1;
        if (nal_type == nure_pkg::TypePrefix || nal_type == nure_pkg::TypeSliceExt) begin
          header_skip_left_next = nure_pkg::ExtHeaderSkip;
        end else if (nal_type == nure_pkg::TypeSliceExt3d) begin
          await_extension_flag_next = 1'b1;
        end
      end
    end else if (bytes_remaining != 32'd0) begin
      bytes_remaining_next = bytes_remaining - 32'd1;
      if (unit_rejected) begin
        // Bytes of a rejected unit are only counted off.
        if (last) begin
          unit_rejected_next = 1'b0;
        end
      end else if (await_extension_flag) begin
        await_extension_flag_next = 1'b0;
        if (last) begin
          header_skip_left_next = '0;
          res.emit     = 1'b1;
          res.unit_end = 1'b1;
        end else begin
          header_skip_left_next = (beat.data_byte & nure_pkg::ExtFlagBit) != 8'd0
                                  ? nure_pkg::Skip3dFlagSet : nure_pkg::Skip3dFlagClr;
        end
      end else if (header_skip_left != 3'd0) begin
        header_skip_left_next = last ? 3'd0 : header_skip_left - 3'd1;
        if (last) begin
          res.emit     = 1'b1;
          res.unit_end = 1'b1;
        end
      end else if (zero_run >= nure_pkg::ZeroRunMax && beat.data_byte == nure_pkg::EpbByte) begin
        // Emulation prevention byte: dropped, and the zero history restarts.
        zero_run_next = '0;
        if (last) begin
          res.emit     = 1'b1;
          res.unit_end = 1'b1;
        end
      end else begin
        if (beat.data_byte == 8'd0) begin
          if (zero_run < nure_pkg::ZeroRunMax) begin
            zero_run_next = zero_run + 2'd1;
          end
        end else begin
          zero_run_next = '0;
        end
        res.emit         = 1'b1;
        res.payload_byte = beat.data_byte;
        res.byte_valid   = 1'b1;
        res.unit_end     = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining      <= '0;
      header_skip_left     <= '0;
      await_extension_flag <= 1'b0;
      zero_run             <= '0;
      unit_rejected        <= 1'b0;
    end else if (fire) begin
      bytes_remaining      <= bytes_remaining_next;
      header_skip_left     <= header_skip_left_next;
      await_extension_flag <= await_extension_flag_next;
      zero_run             <= zero_run_next;
      unit_rejected        <= unit_rejected_next;
    end
  end

endmodule

@@ src/nal_unit_rbsp_extract.sv @@
`timescale 1ns / 1ps
`include "nal_unit_rbsp_extract_macros.svh"

// NAL unit payload extractor. Bytes of one H.264 NAL unit enter one beat at a
// time, with unit_start and unit_length on the first byte. The block drops the
// NAL header (one byte, plus the extension header bytes of types 14, 20 and 21)
// and removes every emulation prevention byte (0x03 after two zero bytes), so
// that the output carries the raw byte sequence payload. Each kept byte gives
// one output beat; the last byte of an accepted unit always gives a beat
// with unit_end set, with byte_valid low if that byte was itself dropped. A
// unit shorter than four bytes gives a single beat with unit_error and
// unit_end on its first byte, and its remaining bytes give nothing. Bytes
// outside a unit are ignored. Throughput is one byte per clock while the
// output is not stalled: the byte passes an input register, and the parsing
// decision (a 32-bit down-count and a few byte compares) sits between that
// register and the output register. The input stalls only when both
// registers are full and the output is stalled.
module nal_unit_rbsp_extract (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        unit_start,
  input  logic [31:0] unit_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        unit_end,
  output logic        unit_error
);

  // Input register stage.
  logic               s1_valid;
  nure_pkg::in_beat_t s1_beat;
  logic               s1_adv;
  logic               s1_fire;
  logic               in_fire;
  nure_pkg::res_t     res;

  // The parsing stage moves on whenever the output register is free or
  // being emptied in this cycle.
  assign s1_adv   = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat.data_byte   <= data_byte;
      s1_beat.unit_start  <= unit_start;
      s1_beat.unit_length <= unit_length;
    end
  end

  nure_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .beat (s1_beat),
    .res  (res)
  );

  // Output register. A byte that produces no result simply passes through
  // the parsing stage and leaves the output register as it was emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= res.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.emit) begin
      payload_byte <= res.payload_byte;
      byte_valid   <= res.byte_valid;
      unit_end     <= res.unit_end;
      unit_error   <= res.unit_error;
    end
  end

  // A beat held in the input register is never lost while the output stalls.
  `NURE_CHECK_NEXT(a_s1_held, s1_valid && !s1_adv, s1_valid)
  // An error beat always closes its unit and carries no byte.
  `NURE_CHECK_SAME(a_error_shape, out_valid && unit_error, unit_end && !byte_valid)
  // A taken output beat is gone unless a new result replaced it.
  `NURE_CHECK_NEXT(a_out_drain, out_valid && !out_stall && !(s1_fire && res.emit), !out_valid)

endmodule
